FILE: rtl/assert_macros.svh
// assertion macros shared by the keypad scan rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked at every rising edge out of reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
// next-cycle implication
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/kmsc_pkg.sv
`default_nettype none

package kmsc_pkg;

    // field widths
    localparam int CMD_W      = 3;
    localparam int KEY_W      = 4;
    localparam int MASK_W     = 3;
    localparam int DATA_W     = 16;
    localparam int CNT_W      = 5;
    localparam int RWAIT_W    = 14;
    localparam int SWAIT_W    = 16;
    localparam int WAIT_W     = 18;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_KEY   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_START = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // scan modes
    localparam logic [MODE_W-1:0] MODE_IDLE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ANY    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CONT   = 2'd3;
    localparam int MODE_SCAN_BIT = 1;
    localparam int MODE_REP_BIT  = 0;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_WAIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_IRQ_ENABLE = 3'd5;

    // register reset values
    localparam logic [CNT_W-1:0] ROW_COUNT_RST = 5'd8;
    localparam logic [CNT_W-1:0] COL_COUNT_RST = 5'd8;

    // status bits
    localparam int ST_DONE = 0;
    localparam int ST_CHG  = 1;
    localparam int ST_ANY  = 2;

    // on key position
    localparam logic [KEY_W-1:0] ON_ROW = 4'd2;
    localparam logic [KEY_W-1:0] ON_COL = 4'd0;

    // extra ticks added to the gap between continuous scans
    localparam logic [WAIT_W-1:0] SCAN_GAP = 18'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load_item;
        logic on_wr;
        logic key_rd;
        logic key_wr;
        logic tick_dec;
        logic scan_rd;
        logic scan_wr;
        logic start;
        logic clr_status;
        logic walk_init;
        logic walk_rd;
        logic walk_rst;
        logic walk_wr;
        logic out_rd;
        logic out_load;
    } ctrl_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             on_key_evt;
        logic             key_in_range;
        logic             scan_active;
        logic             wait_zero;
        logic             mode_any;
        logic             rows_zero;
        logic             walk_last;
    } dp_sts_t;

endpackage

`default_nettype wire

FILE: rtl/kmsc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module kmsc_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    output logic                     m_valid,
    input  wire logic                m_ready,
    input  wire kmsc_pkg::dp_sts_t   sts,
    output kmsc_pkg::ctrl_cmd_t      cmd
);
    import kmsc_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE    = 12'b0000_0000_0001,
        ST_DECODE  = 12'b0000_0000_0010,
        ST_KEY_RD  = 12'b0000_0000_0100,
        ST_KEY_WR  = 12'b0000_0000_1000,
        ST_SCAN_RD = 12'b0000_0001_0000,
        ST_SCAN_WR = 12'b0000_0010_0000,
        ST_ANY_CHK = 12'b0000_0100_0000,
        ST_ANY_RD  = 12'b0000_1000_0000,
        ST_ANY_ACC = 12'b0001_0000_0000,
        ST_ANY_WR  = 12'b0010_0000_0000,
        ST_OUT_RD  = 12'b0100_0000_0000,
        ST_OUT_LD  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.cmd)
                    CMD_KEY: begin
                        if (sts.on_key_evt) begin
                            cmd.on_wr  = 1'b1;
                            state_next = ST_OUT_RD;
                        end else if (sts.key_in_range) begin
                            state_next = ST_KEY_RD;
                        end else begin
                            state_next = ST_OUT_RD;
                        end
                    end
                    CMD_TICK: begin
                        if (sts.scan_active && sts.wait_zero) begin
                            state_next = ST_SCAN_RD;
                        end else begin
                            cmd.tick_dec = sts.scan_active;
                            state_next   = ST_OUT_RD;
                        end
                    end
                    CMD_START: begin
                        cmd.start  = 1'b1;
                        state_next = ST_ANY_CHK;
                    end
                    CMD_CLEAR: begin
                        cmd.clr_status = 1'b1;
                        state_next     = ST_ANY_CHK;
                    end
                    default: begin
                        state_next = ST_OUT_RD;
                    end
                endcase
            end
            ST_KEY_RD: begin
                cmd.key_rd = 1'b1;
                state_next = ST_KEY_WR;
            end
            ST_KEY_WR: begin
                cmd.key_wr = 1'b1;
                state_next = ST_ANY_CHK;
            end
            ST_SCAN_RD: begin
                cmd.scan_rd = 1'b1;
                state_next  = ST_SCAN_WR;
            end
            ST_SCAN_WR: begin
                cmd.scan_wr = 1'b1;
                state_next  = ST_OUT_RD;
            end
            ST_ANY_CHK: begin
                if (sts.mode_any && !sts.rows_zero) begin
                    cmd.walk_init = 1'b1;
                    state_next    = ST_ANY_RD;
                end else begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_ANY_RD: begin
                cmd.walk_rd = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_ANY_ACC;
                end
            end
            ST_ANY_ACC: begin
                cmd.walk_rst = 1'b1;
                state_next   = ST_ANY_WR;
            end
            ST_ANY_WR: begin
                cmd.walk_wr = 1'b1;
                if (sts.walk_last) begin
                    state_next = ST_OUT_RD;
                end
            end
            ST_OUT_RD: begin
                cmd.out_rd = 1'b1;
                state_next = ST_OUT_LD;
            end
            ST_OUT_LD: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    `ASSERT_IMP(a_walk_mode, aclk, aresetn, state_reg == ST_ANY_RD, sts.mode_any)
    `ASSERT_IMP(a_out_free, aclk, aresetn, cmd.out_load, !m_valid_reg || m_ready)
    `ASSERT_IMP(a_scan_pair, aclk, aresetn, cmd.scan_wr, $past(cmd.scan_rd))

endmodule

`default_nettype wire

FILE: rtl/kmsc_dp.sv
`default_nettype none
`include "assert_macros.svh"

module kmsc_dp #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kmsc_pkg::CFG_IDX_W-1:0]    cfg_wr_idx,
    input  wire logic [kmsc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic [kmsc_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_key_row,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_key_col,
    input  wire logic                              s_pressed,
    input  wire logic [kmsc_pkg::MASK_W-1:0]       s_clear_mask,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_read_row,
    input  wire kmsc_pkg::ctrl_cmd_t               cmd,
    output kmsc_pkg::dp_sts_t                      sts,
    output logic                                   m_irq,
    output logic [kmsc_pkg::MASK_W-1:0]            m_status_bits,
    output logic [kmsc_pkg::DATA_W-1:0]            m_row_data,
    output logic                                   m_on_key
);
    import kmsc_pkg::*;

    localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int MEM_DEPTH = 1 << ROW_AW;
    localparam logic [CNT_W-1:0]  ROWS_LIM = CNT_W'(MAX_ROWS);
    localparam logic [CNT_W-1:0]  COLS_LIM = CNT_W'(MAX_COLS);
    localparam logic [DATA_W:0]   BIT_ONE  = (DATA_W+1)'(1);

    // captured item
    logic [CMD_W-1:0]  cmd_reg;
    logic [KEY_W-1:0]  key_row_reg;
    logic [KEY_W-1:0]  key_col_reg;
    logic              pressed_reg;
    logic [MASK_W-1:0] clear_mask_reg;
    logic [KEY_W-1:0]  read_row_reg;

    // configuration
    logic [MODE_W-1:0]  scan_mode_reg;
    logic [CNT_W-1:0]   row_count_reg;
    logic [CNT_W-1:0]   col_count_reg;
    logic [RWAIT_W-1:0] row_wait_reg;
    logic [SWAIT_W-1:0] scan_wait_reg;
    logic [MASK_W-1:0]  irq_en_reg;

    // scan state
    logic [MASK_W-1:0] status_reg, status_next;
    logic [CNT_W-1:0]  scan_row_reg, scan_row_next;
    logic [WAIT_W-1:0] wait_count_reg, wait_next;
    logic [MODE_W-1:0] active_mode_reg, mode_next;
    logic              on_level_reg, on_next;

    // row stores
    logic [MAX_COLS-1:0] key_map_mem   [MEM_DEPTH];
    logic [MAX_COLS-1:0] press_mem     [MEM_DEPTH];
    logic [MAX_COLS-1:0] row_data_mem  [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] km_vld_reg, pl_vld_reg, rds_vld_reg;
    logic [MAX_COLS-1:0] km_rd_reg, pl_rd_reg, rds_rd_reg;

    // any-key walk
    logic [MAX_COLS-1:0] acc_reg;
    logic                acc_en_reg;
    logic [CNT_W-1:0]    walk_row_reg;
    logic                rd_hit_reg;

    // result register
    logic              irq_reg;
    logic [MASK_W-1:0] status_out_reg;
    logic [DATA_W-1:0] row_data_reg;
    logic              on_key_reg;

    logic [CNT_W-1:0]    eff_rows, eff_cols;
    logic [DATA_W:0]     mask_wide;
    logic [MAX_COLS-1:0] col_mask, key_bit, scan_d, acc_masked;
    logic [ROW_AW-1:0]   mem_addr;
    logic [CNT_W-1:0]    scan_row_inc;
    logic                scan_hit, scan_more, rd_en;
    logic                km_we, pl_we, rds_we;
    logic [MAX_COLS-1:0] km_wdata, pl_wdata, rds_wdata;

    // item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            cmd_reg        <= s_cmd;
            key_row_reg    <= s_key_row;
            key_col_reg    <= s_key_col;
            pressed_reg    <= s_pressed;
            clear_mask_reg <= s_clear_mask;
            read_row_reg   <= s_read_row;
        end
    end

    // register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_mode_reg <= MODE_IDLE;
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
            row_wait_reg  <= '0;
            scan_wait_reg <= '0;
            irq_en_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_idx)
                REG_SCAN_MODE:  scan_mode_reg <= cfg_wr_data[MODE_W-1:0];
                REG_ROW_COUNT:  row_count_reg <= cfg_wr_data[CNT_W-1:0];
                REG_COL_COUNT:  col_count_reg <= cfg_wr_data[CNT_W-1:0];
                REG_ROW_WAIT:   row_wait_reg  <= cfg_wr_data[RWAIT_W-1:0];
                REG_SCAN_WAIT:  scan_wait_reg <= cfg_wr_data[SWAIT_W-1:0];
                REG_IRQ_ENABLE: irq_en_reg    <= cfg_wr_data[MASK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // saturated counts and column mask
    assign eff_rows   = (row_count_reg > ROWS_LIM) ? ROWS_LIM : row_count_reg;
    assign eff_cols   = (col_count_reg > COLS_LIM) ? COLS_LIM : col_count_reg;
    assign mask_wide  = (BIT_ONE << eff_cols) - BIT_ONE;
    assign col_mask   = mask_wide[MAX_COLS-1:0];
    assign key_bit    = MAX_COLS'(BIT_ONE << key_col_reg);
    assign scan_d     = (km_rd_reg | pl_rd_reg) & col_mask;
    assign acc_masked = acc_reg & col_mask;

    assign scan_row_inc = scan_row_reg + CNT_W'(1);
    assign scan_hit     = scan_row_reg < eff_rows;
    assign scan_more    = scan_row_inc < row_count_reg;

    // shared row address
    always_comb begin
        if (cmd.key_rd || cmd.key_wr) begin
            mem_addr = key_row_reg[ROW_AW-1:0];
        end else if (cmd.scan_rd || cmd.scan_wr) begin
            mem_addr = scan_row_reg[ROW_AW-1:0];
        end else if (cmd.walk_rd || cmd.walk_wr) begin
            mem_addr = walk_row_reg[ROW_AW-1:0];
        end else begin
            mem_addr = read_row_reg[ROW_AW-1:0];
        end
    end

    // store write controls
    assign rd_en     = cmd.key_rd || cmd.scan_rd || cmd.walk_rd || cmd.out_rd;
    assign km_we     = cmd.key_wr;
    assign km_wdata  = pressed_reg ? (km_rd_reg | key_bit) : (km_rd_reg & ~key_bit);
    assign pl_we     = (cmd.key_wr && pressed_reg) || (cmd.scan_rd && scan_hit) || cmd.walk_rd;
    assign pl_wdata  = cmd.key_wr ? (pl_rd_reg | key_bit) : '0;
    assign rds_we    = (cmd.scan_wr && scan_hit) || cmd.walk_wr;
    assign rds_wdata = cmd.walk_wr ? acc_masked : scan_d;

    // key map store
    always_ff @(posedge aclk) begin
        if (km_we) begin
            key_map_mem[mem_addr] <= km_wdata;
        end
        if (rd_en) begin
            km_rd_reg <= km_vld_reg[mem_addr] ? key_map_mem[mem_addr] : '0;
        end
    end

    // press latch store
    always_ff @(posedge aclk) begin
        if (pl_we) begin
            press_mem[mem_addr] <= pl_wdata;
        end
        if (rd_en) begin
            pl_rd_reg <= pl_vld_reg[mem_addr] ? press_mem[mem_addr] : '0;
        end
    end

    // latched row data store
    always_ff @(posedge aclk) begin
        if (rds_we) begin
            row_data_mem[mem_addr] <= rds_wdata;
        end
        if (rd_en) begin
            rds_rd_reg <= rds_vld_reg[mem_addr] ? row_data_mem[mem_addr] : '0;
        end
    end

    // entry valid bits, unwritten entries read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            km_vld_reg  <= '0;
            pl_vld_reg  <= '0;
            rds_vld_reg <= '0;
        end else begin
            if (km_we) begin
                km_vld_reg[mem_addr] <= 1'b1;
            end
            if (pl_we) begin
                pl_vld_reg[mem_addr] <= 1'b1;
            end
            if (rds_we) begin
                rds_vld_reg[mem_addr] <= 1'b1;
            end
        end
    end

    // any-key accumulate, one row behind the read
    always_ff @(posedge aclk) begin
        if (cmd.walk_init) begin
            acc_reg <= '0;
        end else if (acc_en_reg) begin
            acc_reg <= acc_reg | km_rd_reg | pl_rd_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_en_reg   <= 1'b0;
            walk_row_reg <= '0;
            rd_hit_reg   <= 1'b0;
        end else begin
            acc_en_reg <= cmd.walk_rd;
            if (cmd.walk_init || cmd.walk_rst) begin
                walk_row_reg <= '0;
            end else if (cmd.walk_rd || cmd.walk_wr) begin
                walk_row_reg <= walk_row_reg + CNT_W'(1);
            end
            if (cmd.out_rd) begin
                rd_hit_reg <= {1'b0, read_row_reg} < ROWS_LIM;
            end
        end
    end

    // status, scan position, timer, mode and ON key level
    always_comb begin
        status_next   = status_reg;
        scan_row_next = scan_row_reg;
        wait_next     = wait_count_reg;
        mode_next     = active_mode_reg;
        on_next       = on_level_reg;
        if (cmd.on_wr) begin
            on_next = pressed_reg;
        end
        if (cmd.clr_status) begin
            status_next = status_reg & ~clear_mask_reg;
        end
        if (cmd.start) begin
            mode_next = scan_mode_reg;
            if (scan_mode_reg[MODE_SCAN_BIT]) begin
                scan_row_next = '0;
                wait_next     = WAIT_W'(row_wait_reg);
            end else begin
                wait_next = '0;
            end
        end
        if (cmd.tick_dec) begin
            wait_next = wait_count_reg - WAIT_W'(1);
        end
        if (cmd.scan_wr) begin
            if (scan_hit && (rds_rd_reg != scan_d)) begin
                status_next[ST_CHG] = 1'b1;
            end
            scan_row_next = scan_row_inc;
            if (scan_more) begin
                wait_next = WAIT_W'(row_wait_reg);
            end else begin
                status_next[ST_DONE] = 1'b1;
                if (active_mode_reg[MODE_REP_BIT]) begin
                    scan_row_next = '0;
                    wait_next     = SCAN_GAP + WAIT_W'(scan_wait_reg) + WAIT_W'(row_wait_reg);
                end else begin
                    mode_next = MODE_IDLE;
                end
            end
        end
        if (cmd.walk_wr && (acc_masked != '0)) begin
            status_next[ST_ANY] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            status_reg      <= '0;
            scan_row_reg    <= '0;
            wait_count_reg  <= '0;
            active_mode_reg <= MODE_IDLE;
            on_level_reg    <= 1'b0;
        end else begin
            status_reg      <= status_next;
            scan_row_reg    <= scan_row_next;
            wait_count_reg  <= wait_next;
            active_mode_reg <= mode_next;
            on_level_reg    <= on_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            irq_reg        <= |(status_reg & irq_en_reg);
            status_out_reg <= status_reg;
            row_data_reg   <= rd_hit_reg ? DATA_W'(rds_rd_reg) : '0;
            on_key_reg     <= on_level_reg;
        end
    end

    assign m_irq         = irq_reg;
    assign m_status_bits = status_out_reg;
    assign m_row_data    = row_data_reg;
    assign m_on_key      = on_key_reg;

    // status toward the controller
    always_comb begin
        sts.cmd          = cmd_reg;
        sts.on_key_evt   = (key_row_reg == ON_ROW) && (key_col_reg == ON_COL);
        sts.key_in_range = ({1'b0, key_row_reg} < ROWS_LIM) && ({1'b0, key_col_reg} < COLS_LIM);
        sts.scan_active  = active_mode_reg[MODE_SCAN_BIT];
        sts.wait_zero    = (wait_count_reg == '0);
        sts.mode_any     = (active_mode_reg == MODE_ANY);
        sts.rows_zero    = (eff_rows == '0);
        sts.walk_last    = (walk_row_reg == (eff_rows - CNT_W'(1)));
    end

    `ASSERT_IMP(a_dec_nonzero, aclk, aresetn, cmd.tick_dec, wait_count_reg != '0)
    `ASSERT_IMP(a_walk_bound, aclk, aresetn, cmd.walk_wr, walk_row_reg < eff_rows)
    `ASSERT_NXT(a_start_mode, aclk, aresetn, cmd.start, active_mode_reg == $past(scan_mode_reg))

endmodule

`default_nettype wire

FILE: rtl/keypad_matrix_scan_controller_unit.sv
`default_nettype none

// Keypad matrix scanner. Each input beat carries one command (key event, tick,
// start, status clear or data-row read) and produces exactly one result beat with
// the interrupt level, status bits, the stored data word of read_row and the ON key
// level. Items are handled one at a time by a state machine that walks three
// 16-entry row stores over one shared address per cycle. Each item is decoded,
// may read and write one row of the stores (scan tick or in-range key event),
// then reads the result row and loads the result register. An any-key check
// (active mode 1) reads all effective rows, then writes the folded result back
// to each of them, one row per cycle. The result register lets the next item be
// accepted while the previous result beat is still waiting. Register writes take effect at once.
module keypad_matrix_scan_controller_unit #(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kmsc_pkg::CFG_IDX_W-1:0]    cfg_wr_idx,
    input  wire logic [kmsc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [kmsc_pkg::CMD_W-1:0]        s_cmd,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_key_row,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_key_col,
    input  wire logic                              s_pressed,
    input  wire logic [kmsc_pkg::MASK_W-1:0]       s_clear_mask,
    input  wire logic [kmsc_pkg::KEY_W-1:0]        s_read_row,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic                                   m_irq,
    output logic [kmsc_pkg::MASK_W-1:0]            m_status_bits,
    output logic [kmsc_pkg::DATA_W-1:0]            m_row_data,
    output logic                                   m_on_key
);
    import kmsc_pkg::*;

    ctrl_cmd_t ctl_cmd;
    dp_sts_t   dp_sts;

    // sequencer
    kmsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (dp_sts),
        .cmd     (ctl_cmd)
    );

    // stores, counters and result register
    kmsc_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_idx    (cfg_wr_idx),
        .cfg_wr_data   (cfg_wr_data),
        .s_cmd         (s_cmd),
        .s_key_row     (s_key_row),
        .s_key_col     (s_key_col),
        .s_pressed     (s_pressed),
        .s_clear_mask  (s_clear_mask),
        .s_read_row    (s_read_row),
        .cmd           (ctl_cmd),
        .sts           (dp_sts),
        .m_irq         (m_irq),
        .m_status_bits (m_status_bits),
        .m_row_data    (m_row_data),
        .m_on_key      (m_on_key)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import kmsc_pkg::*;

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 7;
    localparam int NUM_ROWS       = 16;
    localparam int NUM_COLS       = 16;
    localparam int SESSIONS       = 12;
    localparam int SESSION_ITEMS  = 46;
    localparam int ITEM_LATENCY   = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int MASK_ALL       = (1 << MASK_W) - 1;

    // command codes the block decodes as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [KEY_W-1:0]  key_row;
        logic [KEY_W-1:0]  key_col;
        logic              pressed;
        logic [MASK_W-1:0] clear_mask;
        logic [KEY_W-1:0]  read_row;
    } kp_cmd_t;

    typedef struct packed {
        logic              irq;
        logic [MASK_W-1:0] status;
        logic [DATA_W-1:0] data;
        logic              on_key;
    } kp_readout_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_idx;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_valid;
    logic                  s_ready;
    kp_cmd_t               cur_cmd;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_irq;
    logic [MASK_W-1:0]     m_status_bits;
    logic [DATA_W-1:0]     m_row_data;
    logic                  m_on_key;

    kp_cmd_t     cmd_q[$];
    kp_readout_t expected_readouts[$];
    logic        took_cmd;
    int          quiet_cycles;
    int          mismatches;
    int          send_idle_pct;
    int          recv_stall_pct;

    // predicted block state
    logic [DATA_W-1:0] key_map    [NUM_ROWS];
    logic [DATA_W-1:0] press_hold [NUM_ROWS];
    logic [DATA_W-1:0] row_store  [NUM_ROWS];
    logic [MASK_W-1:0] status_q;
    logic [CNT_W-1:0]  scan_ptr;
    logic [WAIT_W-1:0] tick_wait;
    logic [MODE_W-1:0] run_mode;
    logic              on_level;

    // predicted register contents
    logic [MODE_W-1:0]  reg_mode;
    logic [CNT_W-1:0]   reg_rows;
    logic [CNT_W-1:0]   reg_cols;
    logic [RWAIT_W-1:0] reg_row_wait;
    logic [SWAIT_W-1:0] reg_scan_wait;
    logic [MASK_W-1:0]  reg_irq_en;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    keypad_matrix_scan_controller_unit #(
        .MAX_ROWS (NUM_ROWS),
        .MAX_COLS (NUM_COLS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_idx    (cfg_wr_idx),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (cur_cmd.cmd),
        .s_key_row     (cur_cmd.key_row),
        .s_key_col     (cur_cmd.key_col),
        .s_pressed     (cur_cmd.pressed),
        .s_clear_mask  (cur_cmd.clear_mask),
        .s_read_row    (cur_cmd.read_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_irq         (m_irq),
        .m_status_bits (m_status_bits),
        .m_row_data    (m_row_data),
        .m_on_key      (m_on_key)
    );

    // counts above the matrix size saturate
    function automatic int rows_used();
        return (reg_rows > NUM_ROWS) ? NUM_ROWS : int'(reg_rows);
    endfunction

    function automatic int cols_used();
        return (reg_cols > NUM_COLS) ? NUM_COLS : int'(reg_cols);
    endfunction

    function automatic logic [DATA_W-1:0] cols_kept();
        logic [DATA_W:0] m;
        m = ((DATA_W + 1)'(1) << cols_used()) - (DATA_W + 1)'(1);
        return m[DATA_W-1:0];
    endfunction

    // any-key mode folds all effective rows together and stores the result in each of them
    function automatic void fold_any_key();
        logic [DATA_W-1:0] any_bits;
        int                n;
        if (run_mode != MODE_ANY) return;
        n = rows_used();
        any_bits = '0;
        for (int r = 0; r < n; r++) begin
            any_bits |= key_map[r] | press_hold[r];
            press_hold[r] = '0;
        end
        any_bits &= cols_kept();
        for (int r = 0; r < n; r++) row_store[r] = any_bits;
        if (any_bits != '0) status_q[ST_ANY] = 1'b1;
    endfunction

    // one timed scan step: latch the current row, then advance, restart or finish
    function automatic void scan_one_row();
        logic [CNT_W-1:0]  row;
        logic [DATA_W-1:0] bits;
        row = scan_ptr;
        scan_ptr = scan_ptr + 1'b1;
        if (row < rows_used()) begin
            bits = (key_map[row[KEY_W-1:0]] | press_hold[row[KEY_W-1:0]]) & cols_kept();
            press_hold[row[KEY_W-1:0]] = '0;
            if (row_store[row[KEY_W-1:0]] != bits) begin
                status_q[ST_CHG] = 1'b1;
                row_store[row[KEY_W-1:0]] = bits;
            end
        end
        if (scan_ptr < reg_rows) begin
            tick_wait = WAIT_W'(reg_row_wait);
        end else begin
            status_q[ST_DONE] = 1'b1;
            if (run_mode[MODE_REP_BIT]) begin
                scan_ptr  = '0;
                tick_wait = SCAN_GAP + WAIT_W'(reg_scan_wait) + WAIT_W'(reg_row_wait);
            end else begin
                run_mode = MODE_IDLE;
            end
        end
    endfunction

    // apply one command to the predicted state and form its readout
    function automatic kp_readout_t keypad_step(kp_cmd_t c);
        kp_readout_t res;
        case (c.cmd)
            CMD_KEY: begin
                if (c.key_row == ON_ROW && c.key_col == ON_COL) begin
                    on_level = c.pressed;
                end else begin
                    if (c.pressed) begin
                        key_map[c.key_row]    |= DATA_W'(1) << c.key_col;
                        press_hold[c.key_row] |= DATA_W'(1) << c.key_col;
                    end else begin
                        key_map[c.key_row] &= ~(DATA_W'(1) << c.key_col);
                    end
                    fold_any_key();
                end
            end
            CMD_TICK: begin
                if (run_mode[MODE_SCAN_BIT]) begin
                    if (tick_wait == '0) scan_one_row();
                    else tick_wait = tick_wait - 1'b1;
                end
            end
            CMD_START: begin
                run_mode = reg_mode;
                if (run_mode[MODE_SCAN_BIT]) begin
                    scan_ptr  = '0;
                    tick_wait = WAIT_W'(reg_row_wait);
                end else begin
                    tick_wait = '0;
                    fold_any_key();
                end
            end
            CMD_CLEAR: begin
                status_q &= ~c.clear_mask;
                fold_any_key();
            end
            default: ;
        endcase
        res.irq    = |(status_q & reg_irq_en);
        res.status = status_q;
        res.data   = row_store[c.read_row];
        res.on_key = on_level;
        return res;
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] cmd, int row, int col, bit pressed,
                                      int mask, int rd);
        kp_cmd_t c;
        c.cmd        = cmd;
        c.key_row    = KEY_W'(row);
        c.key_col    = KEY_W'(col);
        c.pressed    = pressed;
        c.clear_mask = MASK_W'(mask);
        c.read_row   = KEY_W'(rd);
        cmd_q.push_back(c);
    endfunction

    // random command, mostly ticks and keys inside the scanned window
    function automatic kp_cmd_t random_cmd();
        kp_cmd_t c;
        int      sel;
        sel          = $urandom_range(99);
        c.key_row    = KEY_W'($urandom_range(NUM_ROWS - 1));
        c.key_col    = KEY_W'($urandom_range(NUM_COLS - 1));
        c.pressed    = 1'($urandom_range(1));
        c.clear_mask = MASK_W'($urandom_range(MASK_ALL));
        c.read_row   = KEY_W'($urandom_range(NUM_ROWS - 1));
        if (sel < 50) begin
            c.cmd = CMD_TICK;
        end else if (sel < 75) begin
            c.cmd = CMD_KEY;
            if (rows_used() != 0 && $urandom_range(3) != 0)
                c.key_row = KEY_W'($urandom_range(rows_used() - 1));
            if (cols_used() != 0 && $urandom_range(3) != 0)
                c.key_col = KEY_W'($urandom_range(cols_used() - 1));
            if ($urandom_range(19) == 0) begin
                c.key_row = ON_ROW;
                c.key_col = ON_COL;
            end
        end else if (sel < 88) begin
            c.cmd = CMD_READ;
        end else if (sel < 94) begin
            c.cmd = CMD_CLEAR;
        end else if (sel < 97) begin
            c.cmd = CMD_START;
        end else begin
            c.cmd = CMD_SPARE_FIRST + CMD_W'($urandom_range(CMD_SPARE_LAST - CMD_SPARE_FIRST));
        end
        return c;
    endfunction

    // register write, mirrored into the predicted registers
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= idx;
        cfg_wr_data <= CFG_DATA_W'(val);
        case (idx)
            REG_SCAN_MODE:  reg_mode      = MODE_W'(val);
            REG_ROW_COUNT:  reg_rows      = CNT_W'(val);
            REG_COL_COUNT:  reg_cols      = CNT_W'(val);
            REG_ROW_WAIT:   reg_row_wait  = RWAIT_W'(val);
            REG_SCAN_WAIT:  reg_scan_wait = SWAIT_W'(val);
            REG_IRQ_ENABLE: reg_irq_en    = MASK_W'(val);
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic setup_regs(int mode, int rows, int cols, int rwait, int swait, int irq_en);
        write_reg(REG_SCAN_MODE, mode);
        write_reg(REG_ROW_COUNT, rows);
        write_reg(REG_COL_COUNT, cols);
        write_reg(REG_ROW_WAIT, rwait);
        write_reg(REG_SCAN_WAIT, swait);
        write_reg(REG_IRQ_ENABLE, irq_en);
        @(posedge aclk);
    endtask

    // wait until every queued command is sent and every readout has come back
    task automatic drain();
        while (cmd_q.size() != 0 || s_valid || expected_readouts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // command driver and readout back-pressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || took_cmd) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_cmd <= cmd_q.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor: predict on each command beat, check each readout beat
    always @(posedge aclk) begin
        kp_readout_t want;
        if (!aresetn) begin
            took_cmd     <= 1'b0;
            quiet_cycles <= 0;
        end else begin
            took_cmd <= s_valid && s_ready;
            if (s_valid && s_ready)
                expected_readouts.push_back(keypad_step(cur_cmd));
            if (m_valid && m_ready) begin
                if (expected_readouts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: readout beat with nothing expected: irq %0b status %0h data %04h on %0b",
                                 $time, m_irq, m_status_bits, m_row_data, m_on_key);
                end else begin
                    want = expected_readouts.pop_front();
                    if (want.irq !== m_irq || want.status !== m_status_bits ||
                        want.data !== m_row_data || want.on_key !== m_on_key) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected irq %0b status %0h data %04h on %0b, got irq %0b status %0h data %04h on %0b",
                                     $time, want.irq, want.status, want.data, want.on_key,
                                     m_irq, m_status_bits, m_row_data, m_on_key);
                    end
                end
            end
            // watchdog on cycles with no beat on either channel
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial begin
        int rows_v;
        int cols_v;
        int rwait_v;
        int swait_v;
        int irq_v;
        int prof;

        aresetn        = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_idx     = '0;
        cfg_wr_data    = '0;
        s_valid        = 1'b0;
        m_ready        = 1'b0;
        cur_cmd        = '0;
        took_cmd       = 1'b0;
        quiet_cycles   = 0;
        mismatches     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;

        // predicted state out of reset
        for (int r = 0; r < NUM_ROWS; r++) begin
            key_map[r]    = '0;
            press_hold[r] = '0;
            row_store[r]  = '0;
        end
        status_q      = '0;
        scan_ptr      = '0;
        tick_wait     = '0;
        run_mode      = MODE_IDLE;
        on_level      = 1'b0;
        reg_mode      = MODE_IDLE;
        reg_rows      = ROW_COUNT_RST;
        reg_cols      = COL_COUNT_RST;
        reg_row_wait  = '0;
        reg_scan_wait = '0;
        reg_irq_en    = '0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes, on key, no-op code, idle start and tick, full clear
        queue_cmd(CMD_READ, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 0, 0, 0, 0, NUM_ROWS - 1);
        queue_cmd(CMD_KEY, NUM_ROWS - 1, NUM_COLS - 1, 1, 0, 0);
        queue_cmd(CMD_KEY, 0, 0, 1, 0, 0);
        queue_cmd(CMD_KEY, ON_ROW, ON_COL, 1, 0, 0);
        queue_cmd(CMD_SPARE_LAST, 0, 0, 0, 0, 0);
        queue_cmd(CMD_START, 0, 0, 0, 0, 0);
        queue_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        queue_cmd(CMD_CLEAR, 0, 0, 0, MASK_ALL, 0);
        drain();

        // directed: one full single scan over the whole matrix
        setup_regs(MODE_SINGLE, NUM_ROWS, NUM_COLS, 0, 0, MASK_ALL);
        queue_cmd(CMD_START, 0, 0, 0, 0, 0);
        for (int i = 0; i < NUM_ROWS; i++) queue_cmd(CMD_TICK, 0, 0, 0, 0, 0);
        queue_cmd(CMD_READ, 0, 0, 0, 0, NUM_ROWS - 1);

        // random sessions under four idling profiles
        for (int k = 0; k < SESSIONS; k++) begin
            drain();
            prof = k / 3;
            send_idle_pct  = (prof == 1) ? 79 : (prof == 3) ? 32 : 0;
            recv_stall_pct = (prof == 2) ? 79 : (prof == 3) ? 32 : 0;
            case (k)
                0: begin rows_v = NUM_ROWS; cols_v = NUM_COLS; end
                1: begin rows_v = 0; cols_v = 0; end
                2: begin rows_v = 20; cols_v = 31; end
                3: begin rows_v = 1; cols_v = 1; end
                default: begin
                    rows_v = $urandom_range(8, 1);
                    cols_v = $urandom_range(NUM_COLS, 1);
                end
            endcase
            rwait_v = (k == 4) ? (1 << RWAIT_W) - 1 : $urandom_range(1);
            swait_v = (k == 5) ? (1 << SWAIT_W) - 1 : $urandom_range(3);
            irq_v   = (k == 0) ? MASK_ALL : (k == 1) ? 0 : $urandom_range(MASK_ALL);
            setup_regs(int'(MODE_ANY) + k % 3, rows_v, cols_v, rwait_v, swait_v, irq_v);
            queue_cmd(CMD_START, 0, 0, 0, 0, 0);
            for (int i = 1; i < SESSION_ITEMS; i++) cmd_q.push_back(random_cmd());
        end

        drain();
        repeat (ITEM_LATENCY) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/kmsc_pkg.sv
rtl/kmsc_ctrl.sv
rtl/kmsc_dp.sv
rtl/keypad_matrix_scan_controller_unit.sv
tb/sv/tb.sv
